// ===== design/fip_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the framed identity probe.
package fip_pkg;

    // Frame parser characters
    localparam logic [7:0] CH_OPEN    = 8'h5B;   // '['
    localparam logic [7:0] CH_CLOSE   = 8'h5D;   // ']'
    localparam logic [7:0] CH_QUOTE   = 8'h22;   // '"'
    localparam logic [7:0] CH_NAME    = 8'h6E;   // 'n'
    localparam logic [7:0] CH_VERSION = 8'h76;   // 'v'

    localparam int MAX_FRAME_DEF = 256;
    localparam int MIN_FRAME     = 3;

    // Text stores: three banks rotate between scratch, name and version
    localparam int TEXT_DEPTH  = 256;
    localparam int TEXT_ADDR_W = $clog2(TEXT_DEPTH);
    localparam logic [TEXT_ADDR_W-1:0] TEXT_MAX = TEXT_ADDR_W'(TEXT_DEPTH - 1);
    localparam int NUM_BANKS   = 3;
    localparam int BANK_W      = $clog2(NUM_BANKS);

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_RETRY   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT = 1'b1;
    localparam logic [CFG_DATA_W-1:0]  RETRY_RESET   = 16'd100;
    localparam logic [CFG_DATA_W-1:0]  TIMEOUT_RESET = 16'd2000;

    // Queues between front, back and the result side
    localparam int QUEUE_DEPTH = 4;
    localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_OTHER   = 2'd0,
        KIND_NAME    = 2'd1,
        KIND_VERSION = 2'd2
    } kind_t;

    // Classified request handed from front to back
    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic       which;
        logic [7:0] idx;
        logic       is_open;
        logic       is_close;
        logic       is_quote;
    } cmd_t;

    // One result
    typedef struct packed {
        logic       send_request;
        logic       frame_accepted;
        kind_t      frame_kind;
        logic       found;
        logic       timed_out;
        logic       busy_res;
        logic [7:0] name_length;
        logic [7:0] version_length;
        logic [7:0] read_char;
    } res_t;

endpackage

// ===== design/fip_fifo.sv =====
`timescale 1ns / 1ps
// Small synchronous queue with occupancy count.
module fip_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           din,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           dout,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             do_push, do_pop;

    assign full    = (level_reg == LVL_W'(DEPTH));
    assign empty   = (level_reg == '0);
    assign level   = level_reg;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = store_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   level_next = level_reg + LVL_W'(1);
            2'b01:   level_next = level_reg - LVL_W'(1);
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LVL_W'(DEPTH))
        else $error("fifo level above depth");

    a_level_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (level_reg == $past(level_reg) + LVL_W'(1)))
        else $error("fifo level did not grow on push");

    a_level_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (level_reg == $past(level_reg) - LVL_W'(1)))
        else $error("fifo level did not drop on pop");
`endif

endmodule

// ===== design/fip_front.sv =====
`timescale 1ns / 1ps
// Front end: takes requests from the input port and classifies them.
module fip_front (
    input  logic          push,
    output logic          full,
    input  logic [1:0]    action,
    input  logic [7:0]    data_byte,
    input  logic          which_string,
    input  logic [7:0]    char_index,
    output logic          cmd_push,
    output fip_pkg::cmd_t cmd_item,
    input  logic          cmd_full
);

    import fip_pkg::*;

    assign full     = cmd_full;
    assign cmd_push = push;

    always_comb
    begin
        cmd_item.op       = op_t'(action);
        cmd_item.data     = data_byte;
        cmd_item.which    = which_string;
        cmd_item.idx      = char_index;
        // byte classes only matter for received bytes
        cmd_item.is_open  = (data_byte == CH_OPEN);
        cmd_item.is_close = (data_byte == CH_CLOSE);
        cmd_item.is_quote = (data_byte == CH_QUOTE);
    end

endmodule

// ===== design/fip_back.sv =====
`timescale 1ns / 1ps
// Back end: probe state, frame parser, text banks and result stage.
module fip_back #(
    parameter int MAX_FRAME = fip_pkg::MAX_FRAME_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [fip_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  logic [fip_pkg::CFG_DATA_W-1:0]     wr_data,
    input  logic                               cmd_empty,
    input  fip_pkg::cmd_t                      cmd_item,
    output logic                               cmd_pop,
    input  logic [fip_pkg::LEVEL_W-1:0]        res_level,
    output logic                               res_push,
    output fip_pkg::res_t                      res_item
);

    import fip_pkg::*;

    localparam int FLW   = $clog2(MAX_FRAME + 2);
    localparam int SUM_W = LEVEL_W + 1;

    typedef enum logic [1:0] {
        QP_NONE   = 2'd0,
        QP_INSIDE = 2'd1,
        QP_CLOSED = 2'd2
    } quote_t;

    // configuration
    logic [15:0] retry_reg;
    logic [15:0] timeout_reg;

    // probe and parser state
    logic                   probing_reg, probing_next;
    logic                   name_found_reg, name_found_next;
    logic                   expired_reg, expired_next;
    logic [15:0]            elapsed_reg, elapsed_next;
    logic [15:0]            next_req_reg, next_req_next;
    logic [FLW-1:0]         frame_len_reg, frame_len_next;
    logic [7:0]             frame_cmd_reg, frame_cmd_next;
    quote_t                 quote_reg, quote_next;
    logic [TEXT_ADDR_W-1:0] scratch_len_reg, scratch_len_next;
    logic [7:0]             name_count_reg, name_count_next;
    logic [7:0]             version_count_reg, version_count_next;
    logic [BANK_W-1:0]      scratch_sel_reg, scratch_sel_next;
    logic [BANK_W-1:0]      name_sel_reg, name_sel_next;
    logic [BANK_W-1:0]      version_sel_reg, version_sel_next;

    // text banks
    logic [7:0]                  text_mem [NUM_BANKS][TEXT_DEPTH];
    logic [NUM_BANKS-1:0][7:0]   rd_data_reg;

    // result stage
    logic              r_valid_reg;
    res_t              r_res_reg;
    logic              r_rd_ok_reg;
    logic [BANK_W-1:0] r_bank_reg;

    logic              fire;
    logic              scratch_we;
    logic              rd_en;
    logic              rd_ok;
    logic [BANK_W-1:0] rd_bank;
    logic [FLW-1:0]    fl_inc;
    logic [15:0]       el_inc;
    logic [16:0]       req_sum;
    logic [7:0]        rd_word;
    res_t              res_e;

    // A request leaves the queue only when the result queue can still take it,
    // counting the one sitting in the result stage.
    assign fire    = !cmd_empty &&
                     ((SUM_W'(res_level) + SUM_W'(r_valid_reg)) < SUM_W'(QUEUE_DEPTH));
    assign cmd_pop = fire;
    assign rd_en   = fire && (cmd_item.op == OP_READ);

    assign fl_inc  = frame_len_reg + FLW'(1);
    assign el_inc  = (elapsed_reg != 16'hFFFF) ? elapsed_reg + 16'd1 : elapsed_reg;
    assign req_sum = {1'b0, el_inc} + {1'b0, retry_reg};

    always_comb
    begin
        probing_next       = probing_reg;
        name_found_next    = name_found_reg;
        expired_next       = expired_reg;
        elapsed_next       = elapsed_reg;
        next_req_next      = next_req_reg;
        frame_len_next     = frame_len_reg;
        frame_cmd_next     = frame_cmd_reg;
        quote_next         = quote_reg;
        scratch_len_next   = scratch_len_reg;
        name_count_next    = name_count_reg;
        version_count_next = version_count_reg;
        scratch_sel_next   = scratch_sel_reg;
        name_sel_next      = name_sel_reg;
        version_sel_next   = version_sel_reg;
        scratch_we         = 1'b0;
        rd_ok              = 1'b0;
        rd_bank            = name_sel_reg;
        res_e              = '0;

        if (fire)
        begin
            unique case (cmd_item.op)
                OP_START:
                begin
                    name_found_next    = 1'b0;
                    elapsed_next       = '0;
                    frame_len_next     = '0;
                    frame_cmd_next     = '0;
                    quote_next         = QP_NONE;
                    scratch_len_next   = '0;
                    name_count_next    = '0;
                    version_count_next = '0;
                    if (timeout_reg == '0)
                    begin
                        probing_next  = 1'b0;
                        expired_next  = 1'b1;
                        next_req_next = '0;
                    end
                    else
                    begin
                        probing_next       = 1'b1;
                        expired_next       = 1'b0;
                        res_e.send_request = 1'b1;
                        next_req_next      = retry_reg;
                    end
                end
                OP_BYTE:
                begin
                    if (probing_reg)
                    begin
                        if (cmd_item.is_open)
                        begin
                            frame_len_next   = FLW'(1);
                            frame_cmd_next   = '0;
                            quote_next       = QP_NONE;
                            scratch_len_next = '0;
                        end
                        else if (frame_len_reg != '0)
                        begin
                            if (fl_inc > FLW'(MAX_FRAME))
                            begin
                                // oversize frame is dropped
                                frame_len_next = '0;
                            end
                            else if (!cmd_item.is_close)
                            begin
                                frame_len_next = fl_inc;
                                if (fl_inc == FLW'(2))
                                begin
                                    frame_cmd_next = cmd_item.data;
                                end
                                if (cmd_item.is_quote)
                                begin
                                    if (quote_reg == QP_NONE)
                                    begin
                                        quote_next = QP_INSIDE;
                                    end
                                    else if (quote_reg == QP_INSIDE)
                                    begin
                                        quote_next = QP_CLOSED;
                                    end
                                end
                                else if (quote_reg == QP_INSIDE && scratch_len_reg != TEXT_MAX)
                                begin
                                    scratch_we       = 1'b1;
                                    scratch_len_next = scratch_len_reg + TEXT_ADDR_W'(1);
                                end
                            end
                            else
                            begin
                                frame_len_next = '0;
                                if (fl_inc >= FLW'(MIN_FRAME))
                                begin
                                    res_e.frame_accepted = 1'b1;
                                    // commit swaps the scratch bank in, no copy
                                    if (frame_cmd_reg == CH_NAME)
                                    begin
                                        res_e.frame_kind = KIND_NAME;
                                        if (quote_reg == QP_CLOSED)
                                        begin
                                            name_sel_next    = scratch_sel_reg;
                                            scratch_sel_next = name_sel_reg;
                                            name_count_next  = scratch_len_reg;
                                        end
                                        else
                                        begin
                                            name_count_next = '0;
                                        end
                                    end
                                    else if (frame_cmd_reg == CH_VERSION)
                                    begin
                                        res_e.frame_kind = KIND_VERSION;
                                        if (quote_reg == QP_CLOSED)
                                        begin
                                            version_sel_next   = scratch_sel_reg;
                                            scratch_sel_next   = version_sel_reg;
                                            version_count_next = scratch_len_reg;
                                        end
                                        else
                                        begin
                                            version_count_next = '0;
                                        end
                                    end
                                end
                                if (name_count_next != '0)
                                begin
                                    name_found_next = 1'b1;
                                    probing_next    = 1'b0;
                                end
                            end
                        end
                    end
                end
                OP_TICK:
                begin
                    if (probing_reg)
                    begin
                        elapsed_next = el_inc;
                        if (el_inc >= timeout_reg)
                        begin
                            probing_next = 1'b0;
                            expired_next = 1'b1;
                        end
                        else if (el_inc >= next_req_reg)
                        begin
                            res_e.send_request = 1'b1;
                            next_req_next      = req_sum[16] ? 16'hFFFF : req_sum[15:0];
                        end
                    end
                end
                OP_READ:
                begin
                    if (cmd_item.which)
                    begin
                        rd_bank = version_sel_reg;
                        rd_ok   = (cmd_item.idx < version_count_reg);
                    end
                    else
                    begin
                        rd_bank = name_sel_reg;
                        rd_ok   = (cmd_item.idx < name_count_reg);
                    end
                end
            endcase
        end

        res_e.found          = name_found_next;
        res_e.timed_out      = expired_next;
        res_e.busy_res       = probing_next;
        res_e.name_length    = name_count_next;
        res_e.version_length = version_count_next;
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_reg   <= RETRY_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_RETRY:   retry_reg   <= wr_data;
                REG_TIMEOUT: timeout_reg <= wr_data;
            endcase
        end
    end

    // state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probing_reg       <= 1'b0;
            name_found_reg    <= 1'b0;
            expired_reg       <= 1'b0;
            elapsed_reg       <= '0;
            next_req_reg      <= '0;
            frame_len_reg     <= '0;
            frame_cmd_reg     <= '0;
            quote_reg         <= QP_NONE;
            scratch_len_reg   <= '0;
            name_count_reg    <= '0;
            version_count_reg <= '0;
            scratch_sel_reg   <= BANK_W'(0);
            name_sel_reg      <= BANK_W'(1);
            version_sel_reg   <= BANK_W'(2);
            r_valid_reg       <= 1'b0;
        end
        else
        begin
            probing_reg       <= probing_next;
            name_found_reg    <= name_found_next;
            expired_reg       <= expired_next;
            elapsed_reg       <= elapsed_next;
            next_req_reg      <= next_req_next;
            frame_len_reg     <= frame_len_next;
            frame_cmd_reg     <= frame_cmd_next;
            quote_reg         <= quote_next;
            scratch_len_reg   <= scratch_len_next;
            name_count_reg    <= name_count_next;
            version_count_reg <= version_count_next;
            scratch_sel_reg   <= scratch_sel_next;
            name_sel_reg      <= name_sel_next;
            version_sel_reg   <= version_sel_next;
            r_valid_reg       <= fire;
        end
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            r_res_reg   <= res_e;
            r_rd_ok_reg <= rd_ok;
            r_bank_reg  <= rd_bank;
        end
    end

    // text banks: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            if (scratch_we && scratch_sel_reg == BANK_W'(b))
            begin
                text_mem[b][scratch_len_reg] <= cmd_item.data;
            end
            if (rd_en)
            begin
                rd_data_reg[b] <= text_mem[b][cmd_item.idx];
            end
        end
    end

    always_comb
    begin
        unique case (r_bank_reg)
            BANK_W'(0): rd_word = rd_data_reg[0];
            BANK_W'(1): rd_word = rd_data_reg[1];
            BANK_W'(2): rd_word = rd_data_reg[2];
            default:    rd_word = '0;
        endcase
        res_item           = r_res_reg;
        res_item.read_char = r_rd_ok_reg ? rd_word : 8'd0;
    end

    assign res_push = r_valid_reg;

`ifndef NO_ASSERTIONS
    a_found_stops: assert property (@(posedge clk) disable iff (!rst_n)
        name_found_reg |-> !probing_reg)
        else $error("probe still running after name found");

    a_expired_stops: assert property (@(posedge clk) disable iff (!rst_n)
        expired_reg |-> !probing_reg)
        else $error("probe still running after timeout");

    a_banks_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (scratch_sel_reg != name_sel_reg) && (scratch_sel_reg != version_sel_reg) &&
        (name_sel_reg != version_sel_reg))
        else $error("text bank assigned twice");

    a_frame_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frame_len_reg <= FLW'(MAX_FRAME))
        else $error("frame length past limit");

    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid_reg |-> (res_level < LEVEL_W'(QUEUE_DEPTH)))
        else $error("result stage fired into a full result queue");
`endif

endmodule

// ===== design/framed_identity_probe_unit.sv =====
`timescale 1ns / 1ps
// Top level of the framed identity probe.
//
// Usage:
//   Input side is a queue: drive action/data_byte/which_string/char_index and
//   raise push; the request is taken at a clock edge where full is low.
//   Result side is a queue: while empty is low the oldest result sits on the
//   result ports; pop at an edge with empty low takes it. Every request gives
//   exactly one result, in order.
//   Configuration: wr_en writes wr_data to retry_interval (wr_index 0) or
//   timeout_ticks (wr_index 1) at the clock edge; write only while idle.
// Throughput: one request per clock while the result side keeps up; the back end
//   does one text bank write or read plus compares per request.
// Path: a taken request passes the request queue, then the back end result
//   stage with its registered bank read, then the result queue.
// Stall: a stalled result side fills the 4-deep result queue, the back end
//   holds, the 4-deep request queue fills and full rises; nothing is lost.
// Reset: queues empty, no probe running, stores empty, retry_interval 100,
//   timeout_ticks 2000. No clearing pass; requests are taken right away.
module framed_identity_probe_unit #(
    parameter int MAX_FRAME = fip_pkg::MAX_FRAME_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [1:0]                      action,
    input  logic [7:0]                      data_byte,
    input  logic                            which_string,
    input  logic [7:0]                      char_index,
    output logic                            empty,
    input  logic                            pop,
    output logic                            send_request,
    output logic                            frame_accepted,
    output logic [1:0]                      frame_kind,
    output logic                            found,
    output logic                            timed_out,
    output logic                            busy_res,
    output logic [7:0]                      name_length,
    output logic [7:0]                      version_length,
    output logic [7:0]                      read_char,
    input  logic                            wr_en,
    input  logic [fip_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [fip_pkg::CFG_DATA_W-1:0]  wr_data
);

    import fip_pkg::*;

    logic               cmd_push;
    logic               cmd_full;
    logic               cmd_empty;
    logic               cmd_pop;
    cmd_t               cmd_in;
    cmd_t               cmd_head;
    logic               res_push;
    res_t               res_in;
    res_t               res_head;
    logic [LEVEL_W-1:0] res_level;

    // front: classify incoming requests
    fip_front u_front (
        .push         (push),
        .full         (full),
        .action       (action),
        .data_byte    (data_byte),
        .which_string (which_string),
        .char_index   (char_index),
        .cmd_push     (cmd_push),
        .cmd_item     (cmd_in),
        .cmd_full     (cmd_full)
    );

    // request queue decouples front from back
    fip_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd_head),
        .empty (cmd_empty),
        .level ()
    );

    // back: probe state, parser and text banks
    fip_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .cmd_empty (cmd_empty),
        .cmd_item  (cmd_head),
        .cmd_pop   (cmd_pop),
        .res_level (res_level),
        .res_push  (res_push),
        .res_item  (res_in)
    );

    // result queue; back end only fires when a slot is free here
    fip_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (),
        .pop   (pop),
        .dout  (res_head),
        .empty (empty),
        .level (res_level)
    );

    assign send_request   = res_head.send_request;
    assign frame_accepted = res_head.frame_accepted;
    assign frame_kind     = res_head.frame_kind;
    assign found          = res_head.found;
    assign timed_out      = res_head.timed_out;
    assign busy_res       = res_head.busy_res;
    assign name_length    = res_head.name_length;
    assign version_length = res_head.version_length;
    assign read_char      = res_head.read_char;

endmodule
